FILE: rtl/hmti_pkg.sv
package hmti_pkg;

    // grid and fixed point geometry
    localparam int MAX_SQUARES  = 256;
    localparam int SQUARE_SHIFT = 3;
    localparam int FRAC_BITS    = 8;
    localparam int FULL_BITS    = FRAC_BITS + SQUARE_SHIFT;
    localparam int CORNER_DIM   = MAX_SQUARES + 1;
    localparam int STORE_DEPTH  = CORNER_DIM * CORNER_DIM;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    // field widths
    localparam int POS_W     = 19;
    localparam int CORNER_W  = 9;
    localparam int H_W       = 24;
    localparam int WIDTH_W   = 9;
    localparam int CFG_W     = 19;
    localparam int CFG_IDX_W = 2;

    // derived datapath widths
    localparam int STRIDE_W = $clog2(MAX_SQUARES + 2);
    localparam int IDX_W    = POS_W - FULL_BITS;
    localparam int MUL_W    = (CORNER_W > IDX_W) ? CORNER_W : IDX_W;
    localparam int LIN_W    = MUL_W + STRIDE_W + 1;
    localparam int WGT_W    = FULL_BITS + 1;
    localparam int DIFF_W   = H_W + 1;
    localparam int TERM_W   = H_W + 2;
    localparam int PROD_W   = WGT_W + 1 + DIFF_W;
    localparam int SUM_W    = H_W + 4;

    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FULL_BITS;

    // reset values of the configuration registers
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(MAX_SQUARES + 1);
    localparam logic [POS_W-1:0]    MAX_X_RESET  = POS_W'(524032);
    localparam logic [POS_W-1:0]    MAX_Z_RESET  = POS_W'(524032);

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z     = CFG_IDX_W'(2);

    typedef struct packed {
        logic                    we;
        logic [LIN_W-1:0]        addr;
        logic signed [H_W-1:0]   data;
    } wr_req_t;

    typedef struct packed {
        logic                    tri_br;
        logic [FULL_BITS-1:0]    fx;
        logic [FULL_BITS-1:0]    fz;
    } tri_ctl_t;

endpackage

FILE: rtl/hmti_corner_store.sv
module hmti_corner_store (
    input  logic                                aclk,
    input  logic                                en,
    input  hmti_pkg::wr_req_t                   wr,
    input  logic                                rd_en,
    input  logic [hmti_pkg::LIN_W-1:0]          rd_base,
    input  logic [hmti_pkg::STRIDE_W-1:0]       stride,
    output logic signed [hmti_pkg::H_W-1:0]     h00,
    output logic signed [hmti_pkg::H_W-1:0]     h10,
    output logic signed [hmti_pkg::H_W-1:0]     h01,
    output logic signed [hmti_pkg::H_W-1:0]     h11
);

    // two copies of the corner grid, each with two read ports
    logic signed [hmti_pkg::H_W-1:0] near_mem [hmti_pkg::STORE_DEPTH];
    logic signed [hmti_pkg::H_W-1:0] far_mem  [hmti_pkg::STORE_DEPTH];

    logic [hmti_pkg::LIN_W-1:0] a00, a10, a01, a11;
    logic                       wr_ok;

    logic signed [hmti_pkg::H_W-1:0] q00_reg, q10_reg, q01_reg, q11_reg;
    logic                            ok00_reg, ok10_reg, ok01_reg, ok11_reg;

    // corner addresses of the square
    assign a00 = rd_base;
    assign a10 = rd_base + hmti_pkg::LIN_W'(1);
    assign a01 = rd_base + hmti_pkg::LIN_W'(stride);
    assign a11 = a01 + hmti_pkg::LIN_W'(1);

    assign wr_ok = wr.we && (wr.addr < hmti_pkg::LIN_W'(hmti_pkg::STORE_DEPTH));

    // near copy: top row of the square
    always_ff @(posedge aclk) begin
        if (en && wr_ok) begin
            near_mem[wr.addr[hmti_pkg::ADDR_W-1:0]] <= wr.data;
        end
        if (en && rd_en) begin
            q00_reg <= near_mem[a00[hmti_pkg::ADDR_W-1:0]];
            q10_reg <= near_mem[a10[hmti_pkg::ADDR_W-1:0]];
        end
    end

    // far copy: bottom row of the square
    always_ff @(posedge aclk) begin
        if (en && wr_ok) begin
            far_mem[wr.addr[hmti_pkg::ADDR_W-1:0]] <= wr.data;
        end
        if (en && rd_en) begin
            q01_reg <= far_mem[a01[hmti_pkg::ADDR_W-1:0]];
            q11_reg <= far_mem[a11[hmti_pkg::ADDR_W-1:0]];
        end
    end

    // reads beyond the grid return zero
    always_ff @(posedge aclk) begin
        if (en && rd_en) begin
            ok00_reg <= a00 < hmti_pkg::LIN_W'(hmti_pkg::STORE_DEPTH);
            ok10_reg <= a10 < hmti_pkg::LIN_W'(hmti_pkg::STORE_DEPTH);
            ok01_reg <= a01 < hmti_pkg::LIN_W'(hmti_pkg::STORE_DEPTH);
            ok11_reg <= a11 < hmti_pkg::LIN_W'(hmti_pkg::STORE_DEPTH);
        end
    end

    assign h00 = ok00_reg ? q00_reg : '0;
    assign h10 = ok10_reg ? q10_reg : '0;
    assign h01 = ok01_reg ? q01_reg : '0;
    assign h11 = ok11_reg ? q11_reg : '0;

endmodule

FILE: rtl/hmti_blend.sv
module hmti_blend (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  hmti_pkg::tri_ctl_t                  ctl,
    input  logic signed [hmti_pkg::H_W-1:0]     h00,
    input  logic signed [hmti_pkg::H_W-1:0]     h10,
    input  logic signed [hmti_pkg::H_W-1:0]     h01,
    input  logic signed [hmti_pkg::H_W-1:0]     h11,
    output logic                                out_valid,
    output logic signed [hmti_pkg::H_W-1:0]     height
);

    logic signed [hmti_pkg::H_W-1:0]    base_next;
    logic signed [hmti_pkg::DIFF_W-1:0] d1_next, d2_next;
    logic [hmti_pkg::WGT_W-1:0]         w1_next, w2_next;

    logic                               d_valid_reg;
    logic signed [hmti_pkg::H_W-1:0]    d_base_reg;
    logic signed [hmti_pkg::DIFF_W-1:0] d1_reg, d2_reg;
    logic [hmti_pkg::WGT_W-1:0]         w1_reg, w2_reg;

    logic signed [hmti_pkg::PROD_W-1:0] p1, p2;

    logic                               e_valid_reg;
    logic signed [hmti_pkg::H_W-1:0]    e_base_reg;
    logic signed [hmti_pkg::TERM_W-1:0] t1_reg, t2_reg;

    logic signed [hmti_pkg::SUM_W-1:0]  sum;
    logic                               sat_hi, sat_lo;

    // pick triangle: anchor corner, edge differences and weights
    always_comb begin
        if (!ctl.tri_br) begin
            base_next = h00;
            d1_next   = hmti_pkg::DIFF_W'(h10) - hmti_pkg::DIFF_W'(h00);
            d2_next   = hmti_pkg::DIFF_W'(h01) - hmti_pkg::DIFF_W'(h00);
            w1_next   = hmti_pkg::WGT_W'(ctl.fx);
            w2_next   = hmti_pkg::WGT_W'(ctl.fz);
        end else begin
            base_next = h11;
            d1_next   = hmti_pkg::DIFF_W'(h01) - hmti_pkg::DIFF_W'(h11);
            d2_next   = hmti_pkg::DIFF_W'(h10) - hmti_pkg::DIFF_W'(h11);
            w1_next   = hmti_pkg::WGT_ONE - hmti_pkg::WGT_W'(ctl.fx);
            w2_next   = hmti_pkg::WGT_ONE - hmti_pkg::WGT_W'(ctl.fz);
        end
    end

    // difference stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_base_reg <= base_next;
            d1_reg     <= d1_next;
            d2_reg     <= d2_next;
            w1_reg     <= w1_next;
            w2_reg     <= w2_next;
        end
    end

    // weighted terms, arithmetic shift floors toward minus infinity
    assign p1 = $signed({1'b0, w1_reg}) * d1_reg;
    assign p2 = $signed({1'b0, w2_reg}) * d2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_base_reg <= d_base_reg;
            t1_reg     <= p1[hmti_pkg::FULL_BITS+hmti_pkg::TERM_W-1:hmti_pkg::FULL_BITS];
            t2_reg     <= p2[hmti_pkg::FULL_BITS+hmti_pkg::TERM_W-1:hmti_pkg::FULL_BITS];
        end
    end

    // final sum with saturation to the height range
    assign sum = hmti_pkg::SUM_W'(e_base_reg) + hmti_pkg::SUM_W'(t1_reg)
               + hmti_pkg::SUM_W'(t2_reg);
    assign sat_hi = !sum[hmti_pkg::SUM_W-1] && (|sum[hmti_pkg::SUM_W-2:hmti_pkg::H_W-1]);
    assign sat_lo = sum[hmti_pkg::SUM_W-1] && !(&sum[hmti_pkg::SUM_W-2:hmti_pkg::H_W-1]);

    always_comb begin
        if (sat_hi) begin
            height = {1'b0, {(hmti_pkg::H_W-1){1'b1}}};
        end else if (sat_lo) begin
            height = {1'b1, {(hmti_pkg::H_W-1){1'b0}}};
        end else begin
            height = sum[hmti_pkg::H_W-1:0];
        end
    end

    assign out_valid = e_valid_reg;

endmodule

FILE: rtl/heightmap_triangle_interpolator.sv
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_command, s_pos_x, s_pos_z, s_corner_x,
//                                         s_corner_z, s_height_in
// m_        out        m_valid / m_ready  m_height_out
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// one beat per cycle on the input while s_ready is high; a query result passes the
// clamp, address, read and blend stages to m_; writes produce no result
// the corner grid is held twice so the four corners of a square are read together;
// all reads and writes meet the grid in one pipeline stage, in beat order
// reset is synchronous; grid has no reset; user must read corners only once written
// a two-entry output buffer holds results; the pipeline stalls only when it is full
module heightmap_triangle_interpolator (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [hmti_pkg::POS_W-1:0]          s_pos_x,
    input  logic [hmti_pkg::POS_W-1:0]          s_pos_z,
    input  logic [hmti_pkg::CORNER_W-1:0]       s_corner_x,
    input  logic [hmti_pkg::CORNER_W-1:0]       s_corner_z,
    input  logic signed [hmti_pkg::H_W-1:0]     s_height_in,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [hmti_pkg::H_W-1:0]     m_height_out,

    input  logic                                cfg_we,
    input  logic [hmti_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hmti_pkg::CFG_W-1:0]          cfg_wdata
);

    // configuration
    logic [hmti_pkg::STRIDE_W-1:0] stride_reg;
    logic [hmti_pkg::POS_W-1:0]    max_x_reg, max_z_reg;
    logic [hmti_pkg::WIDTH_W-1:0]  width_val;
    logic [hmti_pkg::STRIDE_W-1:0] stride_next;

    // pipeline control
    logic pipe_en, accept;

    // clamp stage
    logic [hmti_pkg::POS_W-1:0]     px_cl, pz_cl;
    logic                           a_valid_reg;
    logic                           a_cmd_reg;
    logic [hmti_pkg::CORNER_W-1:0]  a_cx_reg, a_cz_reg;
    logic signed [hmti_pkg::H_W-1:0] a_h_reg;
    logic [hmti_pkg::IDX_W-1:0]     a_ix_reg, a_iz_reg;
    logic [hmti_pkg::FULL_BITS-1:0] a_fx_reg, a_fz_reg;

    // address stage
    logic [hmti_pkg::MUL_W-1:0]     mul_row, mul_col;
    logic [hmti_pkg::LIN_W-1:0]     lin_next;
    logic [hmti_pkg::FULL_BITS:0]   frac_sum;
    logic                           b_valid_reg;
    logic                           b_cmd_reg;
    logic [hmti_pkg::LIN_W-1:0]     b_lin_reg;
    logic signed [hmti_pkg::H_W-1:0] b_h_reg;
    hmti_pkg::tri_ctl_t             b_ctl_reg;
    hmti_pkg::wr_req_t              wr_req;
    logic                           rd_en;

    // read stage
    logic                           c_valid_reg;
    hmti_pkg::tri_ctl_t             c_ctl_reg;
    logic signed [hmti_pkg::H_W-1:0] h00, h10, h01, h11;

    // blend output
    logic                           e_valid;
    logic signed [hmti_pkg::H_W-1:0] e_height;

    // output buffer
    logic signed [hmti_pkg::H_W-1:0] obuf_reg [2];
    logic                           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                     cnt_reg, cnt_next;
    logic                           push, pop;

    // width register clamped to the grid, kept as row stride
    assign width_val = cfg_wdata[hmti_pkg::WIDTH_W-1:0];

    always_comb begin
        if (width_val == '0) begin
            stride_next = hmti_pkg::STRIDE_W'(2);
        end else if (width_val > hmti_pkg::WIDTH_W'(hmti_pkg::MAX_SQUARES)) begin
            stride_next = hmti_pkg::STRIDE_W'(hmti_pkg::MAX_SQUARES + 1);
        end else begin
            stride_next = hmti_pkg::STRIDE_W'(width_val) + hmti_pkg::STRIDE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg <= hmti_pkg::STRIDE_RESET;
            max_x_reg  <= hmti_pkg::MAX_X_RESET;
            max_z_reg  <= hmti_pkg::MAX_Z_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                hmti_pkg::CFG_MAP_WIDTH: stride_reg <= stride_next;
                hmti_pkg::CFG_MAX_X:     max_x_reg  <= cfg_wdata[hmti_pkg::POS_W-1:0];
                hmti_pkg::CFG_MAX_Z:     max_z_reg  <= cfg_wdata[hmti_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless the output buffer is full
    assign pipe_en = (cnt_reg != 2'd2);
    assign s_ready = pipe_en;
    assign accept  = s_valid && s_ready;

    // clamp to the configured maximum and split into square and fraction
    assign px_cl = (s_pos_x > max_x_reg) ? max_x_reg : s_pos_x;
    assign pz_cl = (s_pos_z > max_z_reg) ? max_z_reg : s_pos_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_cmd_reg <= s_command;
            a_cx_reg  <= s_corner_x;
            a_cz_reg  <= s_corner_z;
            a_h_reg   <= s_height_in;
            a_ix_reg  <= px_cl[hmti_pkg::POS_W-1:hmti_pkg::FULL_BITS];
            a_iz_reg  <= pz_cl[hmti_pkg::POS_W-1:hmti_pkg::FULL_BITS];
            a_fx_reg  <= px_cl[hmti_pkg::FULL_BITS-1:0];
            a_fz_reg  <= pz_cl[hmti_pkg::FULL_BITS-1:0];
        end
    end

    // linear corner address, one multiplier shared by writes and queries
    always_comb begin
        if (a_cmd_reg == hmti_pkg::CMD_WRITE) begin
            mul_row = hmti_pkg::MUL_W'(a_cz_reg);
            mul_col = hmti_pkg::MUL_W'(a_cx_reg);
        end else begin
            mul_row = hmti_pkg::MUL_W'(a_iz_reg);
            mul_col = hmti_pkg::MUL_W'(a_ix_reg);
        end
    end

    assign lin_next = hmti_pkg::LIN_W'(mul_row) * hmti_pkg::LIN_W'(stride_reg)
                    + hmti_pkg::LIN_W'(mul_col);
    assign frac_sum = {1'b0, a_fx_reg} + {1'b0, a_fz_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            b_cmd_reg        <= a_cmd_reg;
            b_lin_reg        <= lin_next;
            b_h_reg          <= a_h_reg;
            b_ctl_reg.tri_br <= frac_sum[hmti_pkg::FULL_BITS];
            b_ctl_reg.fx     <= a_fx_reg;
            b_ctl_reg.fz     <= a_fz_reg;
        end
    end

    // grid access: writes and reads in beat order, so no forwarding is needed
    assign wr_req.we   = b_valid_reg && (b_cmd_reg == hmti_pkg::CMD_WRITE);
    assign wr_req.addr = b_lin_reg;
    assign wr_req.data = b_h_reg;
    assign rd_en       = b_valid_reg && (b_cmd_reg == hmti_pkg::CMD_QUERY);

    hmti_corner_store u_store (
        .aclk    (aclk),
        .en      (pipe_en),
        .wr      (wr_req),
        .rd_en   (rd_en),
        .rd_base (b_lin_reg),
        .stride  (stride_reg),
        .h00     (h00),
        .h10     (h10),
        .h01     (h01),
        .h11     (h11)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            c_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c_ctl_reg <= b_ctl_reg;
        end
    end

    hmti_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (c_valid_reg),
        .ctl       (c_ctl_reg),
        .h00       (h00),
        .h10       (h10),
        .h01       (h01),
        .h11       (h11),
        .out_valid (e_valid),
        .height    (e_height)
    );

    // two-entry output buffer
    assign push     = pipe_en && e_valid;
    assign pop      = m_valid && m_ready;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            obuf_reg[wr_ptr_reg] <= e_height;
        end
    end

    assign m_valid      = (cnt_reg != 2'd0);
    assign m_height_out = obuf_reg[rd_ptr_reg];

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_cnt_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("output buffer lost a pushed result");

    a_write_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && b_valid_reg && (b_cmd_reg == hmti_pkg::CMD_WRITE)) |=> !c_valid_reg)
        else $error("write beat entered the blend path");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> ($stable(c_valid_reg) && $stable(b_lin_reg)))
        else $error("pipeline moved while stalled");

endmodule

FILE: tb/tb_heightmap_triangle_interpolator.sv
`timescale 1ns / 100ps

module tb_heightmap_triangle_interpolator;

    localparam longint SQ_ONE           = longint'(1) << hmti_pkg::FULL_BITS;
    localparam int     POS_ALL          = (1 << hmti_pkg::POS_W) - 1;
    localparam int     CORNER_ALL       = (1 << hmti_pkg::CORNER_W) - 1;
    localparam longint H_MAX            = (longint'(1) << (hmti_pkg::H_W - 1)) - 1;
    localparam longint H_MIN            = -(longint'(1) << (hmti_pkg::H_W - 1));
    localparam logic [hmti_pkg::CFG_IDX_W-1:0] CFG_SPARE = hmti_pkg::CFG_IDX_W'(3);

    localparam int IDLE_MAX         = 6;
    localparam int RESET_CYCLES     = 9;
    localparam int SETTLE_CYCLES    = 12;
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int HOLD_MIN_PENDING = 20;
    localparam int RANDOM_PHASES    = 9;
    localparam int ITEMS_PER_HALF   = 40;
    localparam int TIMEOUT_NS       = 2_000_000;

    // one input beat
    typedef struct {
        logic                            cmd;
        logic [hmti_pkg::POS_W-1:0]      px;
        logic [hmti_pkg::POS_W-1:0]      pz;
        logic [hmti_pkg::CORNER_W-1:0]   cx;
        logic [hmti_pkg::CORNER_W-1:0]   cz;
        logic signed [hmti_pkg::H_W-1:0] h;
    } beat_t;

    // triangle picked by a query: apex corner, two neighbors and their weights
    typedef struct {
        longint apex;
        longint n1;
        longint n2;
        longint w1;
        longint w2;
    } tri_t;

    logic                              aclk         = 1'b0;
    logic                              aresetn      = 1'b0;
    logic                              s_valid      = 1'b0;
    logic                              s_ready;
    logic                              s_command    = hmti_pkg::CMD_WRITE;
    logic [hmti_pkg::POS_W-1:0]        s_pos_x      = '0;
    logic [hmti_pkg::POS_W-1:0]        s_pos_z      = '0;
    logic [hmti_pkg::CORNER_W-1:0]     s_corner_x   = '0;
    logic [hmti_pkg::CORNER_W-1:0]     s_corner_z   = '0;
    logic signed [hmti_pkg::H_W-1:0]   s_height_in  = '0;
    logic                              m_valid;
    logic                              m_ready      = 1'b0;
    logic signed [hmti_pkg::H_W-1:0]   m_height_out;
    logic                              cfg_we       = 1'b0;
    logic [hmti_pkg::CFG_IDX_W-1:0]    cfg_index    = hmti_pkg::CFG_MAP_WIDTH;
    logic [hmti_pkg::CFG_W-1:0]        cfg_wdata    = '0;

    // predictor state: configuration copy and corner grid
    logic [hmti_pkg::WIDTH_W-1:0]      map_width_q = hmti_pkg::WIDTH_W'(hmti_pkg::MAX_SQUARES);
    logic [hmti_pkg::POS_W-1:0]        max_x_q     = hmti_pkg::MAX_X_RESET;
    logic [hmti_pkg::POS_W-1:0]        max_z_q     = hmti_pkg::MAX_Z_RESET;
    logic signed [hmti_pkg::H_W-1:0]   grid_heights [hmti_pkg::STORE_DEPTH];
    bit                                corner_known [hmti_pkg::STORE_DEPTH];

    beat_t                             pending_beats [$];
    beat_t                             cur_beat;
    logic signed [hmti_pkg::H_W-1:0]   expected_heights [$];

    int unsigned send_gap_max   = IDLE_MAX;
    int unsigned recv_stall_max = IDLE_MAX;
    int unsigned idle_left      = 0;
    int unsigned stall_left     = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;

    heightmap_triangle_interpolator uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_pos_x      (s_pos_x),
        .s_pos_z      (s_pos_z),
        .s_corner_x   (s_corner_x),
        .s_corner_z   (s_corner_z),
        .s_height_in  (s_height_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_height_out (m_height_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // corner row stride, width clamped to 1..MAX_SQUARES
    function automatic longint row_stride();
        longint w;
        w = map_width_q;
        if (w == 0) w = 1;
        if (w > hmti_pkg::MAX_SQUARES) w = hmti_pkg::MAX_SQUARES;
        return w + 1;
    endfunction

    function automatic longint corner_addr(logic [hmti_pkg::CORNER_W-1:0] cx,
                                           logic [hmti_pkg::CORNER_W-1:0] cz);
        return longint'(cz) * row_stride() + longint'(cx);
    endfunction

    function automatic longint corner_at(longint a);
        if (a >= hmti_pkg::STORE_DEPTH) return 0;
        return grid_heights[a];
    endfunction

    // clamp, split into square and fractions, pick the triangle
    function automatic tri_t pick_triangle(logic [hmti_pkg::POS_W-1:0] px_in,
                                           logic [hmti_pkg::POS_W-1:0] pz_in);
        tri_t   t;
        longint px, pz, fx, fz, hs, st;
        px = (px_in > max_x_q) ? max_x_q : px_in;
        pz = (pz_in > max_z_q) ? max_z_q : pz_in;
        fx = px & (SQ_ONE - 1);
        fz = pz & (SQ_ONE - 1);
        st = row_stride();
        hs = (px >> hmti_pkg::FULL_BITS) + (pz >> hmti_pkg::FULL_BITS) * st;
        if (fx + fz < SQ_ONE) begin
            t.apex = hs;
            t.n1   = hs + 1;
            t.w1   = fx;
            t.n2   = hs + st;
            t.w2   = fz;
        end else begin
            t.apex = hs + st + 1;
            t.n1   = hs + st;
            t.w1   = SQ_ONE - fx;
            t.n2   = hs + 1;
            t.w2   = SQ_ONE - fz;
        end
        return t;
    endfunction

    function automatic longint rand_height();
        case ($urandom_range(7, 0))
            0: return H_MAX;
            1: return H_MIN;
            2: return longint'($urandom_range(15, 0)) - 8;
            default: return longint'($urandom_range(int'(H_MAX - H_MIN), 0)) + H_MIN;
        endcase
    endfunction

    // coordinate biased to the clamp limit, the field extremes and fraction edges
    function automatic longint rand_coord(longint maxv);
        int unsigned m;
        m = int'(maxv);
        case ($urandom_range(9, 0))
            0: return 0;
            1: return maxv;
            2: return POS_ALL;
            3: return $urandom_range(POS_ALL, 0);
            4: return longint'($urandom_range(m, 0)) | (SQ_ONE - 1);
            5: return longint'($urandom_range(m, 0)) & ~(SQ_ONE - 1);
            default: return $urandom_range(m, 0);
        endcase
    endfunction

    function automatic void push_write(int unsigned cx, int unsigned cz, longint h);
        beat_t  b;
        longint a;
        b.cmd = hmti_pkg::CMD_WRITE;
        b.px  = hmti_pkg::POS_W'($urandom);
        b.pz  = hmti_pkg::POS_W'($urandom);
        b.cx  = cx[hmti_pkg::CORNER_W-1:0];
        b.cz  = cz[hmti_pkg::CORNER_W-1:0];
        b.h   = h[hmti_pkg::H_W-1:0];
        a = corner_addr(b.cx, b.cz);
        if (a < hmti_pkg::STORE_DEPTH) corner_known[a] = 1'b1;
        pending_beats.push_back(b);
    endfunction

    // query beat, preceded by writes of any corner it reads that is still unset
    function automatic void push_query(longint px, longint pz);
        beat_t  b;
        tri_t   t;
        longint need [3];
        longint st, cx, cz;
        b.cmd = hmti_pkg::CMD_QUERY;
        b.px  = px[hmti_pkg::POS_W-1:0];
        b.pz  = pz[hmti_pkg::POS_W-1:0];
        b.cx  = hmti_pkg::CORNER_W'($urandom);
        b.cz  = hmti_pkg::CORNER_W'($urandom);
        b.h   = hmti_pkg::H_W'($urandom);
        t = pick_triangle(b.px, b.pz);
        need = '{t.apex, t.n1, t.n2};
        st = row_stride();
        foreach (need[i]) begin
            if (need[i] < hmti_pkg::STORE_DEPTH && !corner_known[need[i]]) begin
                cz = need[i] / st;
                cx = need[i] % st;
                // now and then reach the corner through a column past the row end
                if (cz > 0 && cx + st <= CORNER_ALL && $urandom_range(3, 0) == 0) begin
                    cz = cz - 1;
                    cx = cx + st;
                end
                push_write(int'(cx), int'(cz), rand_height());
            end
        end
        pending_beats.push_back(b);
    endfunction

    task automatic cfg_write(input logic [hmti_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hmti_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            hmti_pkg::CFG_MAP_WIDTH: map_width_q = val[hmti_pkg::WIDTH_W-1:0];
            hmti_pkg::CFG_MAX_X:     max_x_q     = val[hmti_pkg::POS_W-1:0];
            hmti_pkg::CFG_MAX_Z:     max_z_q     = val[hmti_pkg::POS_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // wait until all beats are in and all heights are out, then let writes settle
    task automatic drain();
        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_heights.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic flag_error(input string msg);
        mismatch_count++;
        $display("[%0t] error: %s", $time, msg);
    endtask

    // input beat driver with the predictor on accepted beats
    always @(posedge aclk) begin : beat_driver
        beat_t  nb;
        tri_t   t;
        longint ha, h, a;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            idle_left <= 0;
        end else begin
            // accepted beat updates the grid or predicts a height
            if (s_valid && s_ready) begin
                if (cur_beat.cmd == hmti_pkg::CMD_WRITE) begin
                    a = corner_addr(cur_beat.cx, cur_beat.cz);
                    if (a < hmti_pkg::STORE_DEPTH) grid_heights[a] = cur_beat.h;
                end else begin
                    t  = pick_triangle(cur_beat.px, cur_beat.pz);
                    ha = corner_at(t.apex);
                    h  = ha + ((t.w1 * (corner_at(t.n1) - ha)) >>> hmti_pkg::FULL_BITS)
                            + ((t.w2 * (corner_at(t.n2) - ha)) >>> hmti_pkg::FULL_BITS);
                    if (h > H_MAX) h = H_MAX;
                    else if (h < H_MIN) h = H_MIN;
                    expected_heights.push_back(h[hmti_pkg::H_W-1:0]);
                end
            end
            // next beat, idle gap, or nothing left
            if (!(s_valid && !s_ready)) begin
                if (idle_left != 0) begin
                    idle_left <= idle_left - 1;
                    s_valid   <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    nb = pending_beats.pop_front();
                    cur_beat    <= nb;
                    s_command   <= nb.cmd;
                    s_pos_x     <= nb.px;
                    s_pos_z     <= nb.pz;
                    s_corner_x  <= nb.cx;
                    s_corner_z  <= nb.cz;
                    s_height_in <= nb.h;
                    s_valid     <= 1'b1;
                    idle_left   <= $urandom_range(send_gap_max, 0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stalls and one long hold while beats are still queued
    always @(posedge aclk) begin : height_monitor
        logic signed [hmti_pkg::H_W-1:0] want;
        int unsigned                     g;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else begin
            g = 0;
            if (m_valid && m_ready) begin
                if (expected_heights.size() == 0) begin
                    flag_error($sformatf("unexpected height %0d", m_height_out));
                end else begin
                    want = expected_heights.pop_front();
                    if (m_height_out !== want)
                        flag_error($sformatf("height got %0d, want %0d", m_height_out, want));
                end
                results_seen++;
                g = $urandom_range(recv_stall_max, 0);
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (!hold_done && results_seen >= LONG_HOLD_AT
                         && pending_beats.size() >= HOLD_MIN_PENDING) begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (g != 0) begin
                stall_left <= g - 1;
                m_ready    <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int unsigned w, mx, mz, span, r;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // square at the origin, both triangles and the diagonal edge
        push_write(0, 0, H_MAX);
        push_write(1, 0, H_MIN);
        push_write(0, 1, 256);
        push_write(1, 1, -5);
        push_query(0, 0);
        push_query(SQ_ONE - 1, 0);
        push_query(0, SQ_ONE - 1);
        push_query(SQ_ONE / 2, SQ_ONE / 2 - 1);
        push_query(SQ_ONE / 2, SQ_ONE / 2);
        push_query(SQ_ONE - 1, SQ_ONE - 1);
        // floor of negative products drives the sum below the minimum
        push_write(2, 0, H_MIN + 1);
        push_write(3, 0, H_MIN);
        push_write(2, 1, H_MIN);
        push_write(3, 1, H_MIN);
        push_query(2 * SQ_ONE + 1, 1);
        // write past the store is dropped, last corner of the store is kept
        push_write(CORNER_ALL, CORNER_ALL, rand_height());
        push_write(hmti_pkg::MAX_SQUARES, hmti_pkg::MAX_SQUARES, rand_height());
        // column past the row end lands in the next row
        push_write(300, 0, -1);
        push_query(42 * SQ_ONE + 100, SQ_ONE + 50);
        // coordinates above the clamp limit
        push_query(POS_ALL, POS_ALL);
        push_query(POS_ALL, 0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       w = 0;
                1:       w = POS_ALL;
                2:       w = 1;
                default: w = ($urandom_range(3, 0) == 0) ? $urandom_range(POS_ALL, 0)
                                                         : $urandom_range(8, 1);
            endcase
            cfg_write(hmti_pkg::CFG_MAP_WIDTH, hmti_pkg::CFG_W'(w));
            span = int'((row_stride() - 1) * SQ_ONE - 1);
            case (p)
                0: begin mx = 0;       mz = 0;       end
                1: begin mx = POS_ALL; mz = POS_ALL; end
                2: begin mx = span;    mz = POS_ALL; end
                default: begin
                    mx = ($urandom_range(4, 0) == 0) ? $urandom_range(POS_ALL, 0)
                                                     : $urandom_range(span, 0);
                    mz = ($urandom_range(4, 0) == 0) ? $urandom_range(POS_ALL, 0)
                                                     : $urandom_range(span, 0);
                end
            endcase
            cfg_write(hmti_pkg::CFG_MAX_X, hmti_pkg::CFG_W'(mx));
            cfg_write(hmti_pkg::CFG_MAX_Z, hmti_pkg::CFG_W'(mz));
            // unused register index is ignored
            if (p == 0) cfg_write(CFG_SPARE, hmti_pkg::CFG_W'($urandom));
            @(negedge aclk);

            case (p % 4)
                0: begin send_gap_max = IDLE_MAX; recv_stall_max = IDLE_MAX; end
                1: begin send_gap_max = 0;        recv_stall_max = IDLE_MAX; end
                2: begin send_gap_max = IDLE_MAX; recv_stall_max = 0;        end
                default: begin send_gap_max = 0;  recv_stall_max = 0;        end
            endcase

            // two bursts, the sender waits for all heights between them
            repeat (2) begin
                repeat (ITEMS_PER_HALF) begin
                    r = $urandom_range(19, 0);
                    if (r < 13)
                        push_query(rand_coord(max_x_q), rand_coord(max_z_q));
                    else if (r < 17)
                        push_write($urandom_range((max_x_q >> hmti_pkg::FULL_BITS) + 1, 0),
                                   $urandom_range((max_z_q >> hmti_pkg::FULL_BITS) + 1, 0),
                                   rand_height());
                    else
                        push_write($urandom_range(CORNER_ALL, 0), $urandom_range(CORNER_ALL, 0),
                                   rand_height());
                end
                drain();
            end
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
